// ----- src/dnt_pkg.sv -----
// dnt_pkg: shared constants, command and status codes, the token that walks the
// cell chain, and the name normalizing function for the directory name table
// no dependencies
package dnt_pkg;

  localparam int ENTRIES     = 16;
  localparam int NAME_CHARS  = 9;
  localparam int SECTOR_BITS = 16;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int NAME_W = NAME_CHARS * 8;

  // port field widths
  localparam int CMD_W      = 2;
  localparam int HEAD_W     = 64;
  localparam int TAIL_W     = 8;
  localparam int NSECT_W    = 16;
  localparam int EIDX_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int FSECT_W    = 16;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNOPENABLE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd4;

  typedef struct packed {
    logic                   valid;
    logic                   done;
    logic [CMD_W-1:0]       cmd;
    logic [NAME_W-1:0]      name;
    logic [SECTOR_BITS-1:0] sector;
    logic                   is_dir;
    logic [EIDX_W-1:0]      index;
    logic [STATUS_W-1:0]    status;
    logic [IDX_W-1:0]       res_index;
    logic [SECTOR_BITS-1:0] res_sector;
  } dnt_token_t;

  // keep NAME_CHARS bytes, zero everything after the first zero byte
  function automatic logic [NAME_W-1:0] form_name(input logic [HEAD_W-1:0] head,
                                                  input logic [TAIL_W-1:0] tail);
    logic [127:0]      raw;
    logic [NAME_W-1:0] nm;
    logic [7:0]        b;
    logic              ended;
    raw   = {56'b0, tail, head};
    nm    = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      b = raw[8*k +: 8];
      if (ended) begin
        b = 8'd0;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      nm[8*k +: 8] = b;
    end
    return nm;
  endfunction

endpackage

// ----- src/dnt_cell.sv -----
// dnt_cell: one table entry of the directory name table; acts on the passing
// command token and hands it on to the next cell through its output register
// depends on dnt_pkg
module dnt_cell
  import dnt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  dnt_token_t       tok_in,
  output dnt_token_t       tok_out
);

  logic                   used;
  logic                   used_next;
  logic                   locked;
  logic                   locked_next;
  logic                   dir;
  logic                   dir_next;
  logic [NAME_W-1:0]      name;
  logic [SECTOR_BITS-1:0] sector;
  logic                   entry_we;
  logic                   hit;
  dnt_token_t             tok_next;

  assign hit = (int'(tok_in.index) == int'(cell_id));

  always_comb begin
    tok_next    = tok_in;
    used_next   = used;
    locked_next = locked;
    dir_next    = dir;
    entry_we    = 1'b0;
    if (tok_in.valid && !tok_in.done) begin
      unique case (tok_in.cmd)
        CMD_FIND: begin
          if (used && (name == tok_in.name)) begin
            tok_next.done      = 1'b1;
            tok_next.res_index = cell_id;
            if (locked) begin
              tok_next.status = ST_UNOPENABLE;
            end else begin
              tok_next.status     = ST_OK;
              tok_next.res_sector = sector;
            end
          end
        end
        CMD_ADD: begin
          if (!used) begin
            used_next          = 1'b1;
            locked_next        = 1'b0;
            dir_next           = tok_in.is_dir;
            entry_we           = 1'b1;
            tok_next.done      = 1'b1;
            tok_next.status    = ST_OK;
            tok_next.res_index = cell_id;
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            used_next     = 1'b0;
            dir_next      = 1'b0;
            tok_next.done = 1'b1;
          end
        end
        CMD_LOCK: begin
          if (hit) begin
            locked_next   = 1'b1;
            tok_next.done = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      locked        <= 1'b0;
      dir           <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      used    <= used_next;
      locked  <= locked_next;
      dir     <= dir_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      name   <= tok_in.name;
      sector <= tok_in.sector;
    end
  end

  a_dir_needs_used: assert property (@(posedge clk) disable iff (rst)
    dir |-> used)
    else $error("directory mark on a free entry");

endmodule

// ----- src/directory_name_table.sv -----
// directory_name_table: top level, input register, row of entry cells and
// result register of the directory name table
// depends on dnt_pkg and dnt_cell
//
// usage:
//   commands arrive on the s_axis channel, cmd in tuser, the other fields in
//   tdata; each command gives exactly one result on the m_axis channel,
//   status in tuser, index and sector in tdata
//   a command token walks the row of ENTRIES cells, one cell per cycle; each
//   cell holds one entry and answers find, add, remove or lock as it passes
//   from input transfer to result valid a command passes the input register,
//   the ENTRIES cells and the result register, in that order
//   one command is in the cell row at a time; a new command enters it only
//   once the last token has left the row and no result waits
//   one command more is taken into the input register while a result waits
//   and waits there until the result register is free
//   reset clears all in-use, unopenable and directory marks and empties the
//   pipeline; names and sectors are written by add only
//   while the receiver stalls the result holds and no new token is launched
module directory_name_table
  import dnt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // name_head[63:0], name_tail[71:64], new_sector[87:72], is_dir[88],
  // entry_index[92:89], zero[95:93]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found_index[3:0], found_sector[19:4], zero[23:20]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  logic [HEAD_W-1:0]   in_head;
  logic [TAIL_W-1:0]   in_tail;
  logic [NSECT_W-1:0]  in_sector;
  logic                in_is_dir;
  logic [EIDX_W-1:0]   in_index;
  logic [CMD_W-1:0]    in_cmd;
  logic                accept;
  logic                launch;
  logic                exit_valid;
  logic                in_full;
  logic                chain_busy;
  dnt_token_t          in_tok;
  dnt_token_t          in_tok_next;
  dnt_token_t          chain [ENTRIES+1];
  logic [ENTRIES:0]    chain_valid;
  logic [STATUS_W-1:0] out_status;
  logic [EIDX_W-1:0]   out_index;
  logic [FSECT_W-1:0]  out_sector;

  assign in_head   = s_axis_tdata[63:0];
  assign in_tail   = s_axis_tdata[71:64];
  assign in_sector = s_axis_tdata[87:72];
  assign in_is_dir = s_axis_tdata[88];
  assign in_index  = s_axis_tdata[92:89];
  assign in_cmd    = s_axis_tuser;

  assign s_axis_tready = !in_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign launch        = in_full && !chain_busy && !m_axis_tvalid;
  assign exit_valid    = chain[ENTRIES].valid;

  // build the token; status starts as the outcome if no cell acts; a bad remove or lock index is marked done at once
  always_comb begin
    in_tok_next            = '0;
    in_tok_next.valid      = 1'b1;
    in_tok_next.cmd        = in_cmd;
    in_tok_next.name       = form_name(in_head, in_tail);
    in_tok_next.sector     = SECTOR_BITS'(in_sector);
    in_tok_next.is_dir     = in_is_dir;
    in_tok_next.index      = in_index;
    in_tok_next.res_index  = '0;
    in_tok_next.res_sector = '0;
    unique case (in_cmd)
      CMD_FIND: begin
        in_tok_next.status = ST_NOT_FOUND;
      end
      CMD_ADD: begin
        in_tok_next.status = ST_FULL;
      end
      CMD_REMOVE: begin
        if (in_index < EIDX_W'(2) || int'(in_index) >= ENTRIES) begin
          in_tok_next.status = ST_BAD_INDEX;
          in_tok_next.done   = 1'b1;
        end else begin
          in_tok_next.status = ST_OK;
        end
      end
      CMD_LOCK: begin
        if (int'(in_index) >= ENTRIES) begin
          in_tok_next.status = ST_BAD_INDEX;
          in_tok_next.done   = 1'b1;
        end else begin
          in_tok_next.status = ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      chain_busy <= 1'b0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (launch) begin
        in_full <= 1'b0;
      end
      if (launch) begin
        chain_busy <= 1'b1;
      end else if (exit_valid) begin
        chain_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_tok <= in_tok_next;
    end
  end

  always_comb begin
    chain[0]       = in_tok;
    chain[0].valid = launch;
  end

  assign chain_valid[0] = chain[0].valid;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dnt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (IDX_W'(g)),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
    assign chain_valid[g+1] = chain[g+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exit_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exit_valid) begin
      out_status <= chain[ENTRIES].status;
      out_index  <= EIDX_W'(chain[ENTRIES].res_index);
      out_sector <= FSECT_W'(chain[ENTRIES].res_sector);
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'b0, out_sector, out_index};

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one token in the cell row");

  a_exit_free: assert property (@(posedge clk) disable iff (rst)
    exit_valid |-> !m_axis_tvalid)
    else $error("token left the cell row onto a pending result");

  a_rose_from_exit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(exit_valid))
    else $error("result appeared without a finished token");

endmodule

// ----- dv/directory_name_table_tb.sv -----
`timescale 1ns / 100ps
// directory_name_table_tb: self-checking bench for the directory name table, directed rows then
// random command mixes, results checked against typed rows or an in-bench entry table model
// depends on dnt_pkg and directory_name_table
module directory_name_table_tb;
  import dnt_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 8;

  localparam int MODE_FILL   = 0;
  localparam int MODE_LOOKUP = 1;
  localparam int MODE_DRAIN  = 2;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
    logic [NSECT_W-1:0] sector;
    logic               is_dir;
    logic [EIDX_W-1:0]  idx;
  } dir_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;
    logic [FSECT_W-1:0]  sector;
  } dir_reply_t;

  typedef struct {
    dir_cmd_t   c;
    bit         typed;
    dir_reply_t r;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = CMD_FIND;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // model of the entry table
  bit                     used_tab   [ENTRIES];
  bit                     locked_tab [ENTRIES];
  bit                     dir_tab    [ENTRIES];
  logic [NAME_W-1:0]      name_tab   [ENTRIES];
  logic [SECTOR_BITS-1:0] sector_tab [ENTRIES];

  dir_reply_t        awaited_replies[$];
  dir_row_t          script[$];
  logic [71:0]       pool_name [POOL_SIZE];
  int                pool_len  [POOL_SIZE];
  int                error_count   = 0;
  int                sent_count    = 0;
  int                results_seen  = 0;
  int                cycle_count   = 0;
  int                status_hits [5];

  directory_name_table i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) @(posedge clk);
    $display("directory_name_table_tb: done, errors");
    $finish;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // bytes past the first zero byte, or past NAME_CHARS, do not count
  function automatic logic [NAME_W-1:0] clean_name(logic [HEAD_W-1:0] head,
                                                   logic [TAIL_W-1:0] tail);
    logic [71:0]       raw;
    logic [NAME_W-1:0] nm;
    bit                ended;
    raw   = {tail, head};
    nm    = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_CHARS && k < 9; k++) begin
      if (raw[8*k +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        nm[8*k +: 8] = raw[8*k +: 8];
      end
    end
    return nm;
  endfunction

  function automatic dir_reply_t predict_reply(dir_cmd_t c);
    dir_reply_t        r;
    logic [NAME_W-1:0] nm;
    bit                hit;
    nm     = clean_name(c.head, c.tail);
    r      = '{status: ST_OK, index: '0, sector: '0};
    hit    = 1'b0;
    case (c.cmd)
      CMD_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && used_tab[i] && name_tab[i] == nm) begin
            hit     = 1'b1;
            r.index = IDX_W'(i);
            if (locked_tab[i]) begin
              r.status = ST_UNOPENABLE;
            end else begin
              r.status = ST_OK;
              r.sector = sector_tab[i];
            end
          end
        end
      end
      CMD_ADD: begin
        r.status = ST_FULL;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!hit && !used_tab[i]) begin
            hit           = 1'b1;
            used_tab[i]   = 1'b1;
            locked_tab[i] = 1'b0;
            dir_tab[i]    = c.is_dir;
            name_tab[i]   = nm;
            sector_tab[i] = c.sector[SECTOR_BITS-1:0];
            r.status      = ST_OK;
            r.index       = IDX_W'(i);
          end
        end
      end
      CMD_REMOVE: begin
        if (c.idx < 2 || c.idx >= ENTRIES) begin
          r.status = ST_BAD_INDEX;
        end else begin
          used_tab[c.idx] = 1'b0;
          dir_tab[c.idx]  = 1'b0;
        end
      end
      default: begin
        if (c.idx >= ENTRIES) begin
          r.status = ST_BAD_INDEX;
        end else begin
          locked_tab[c.idx] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [HEAD_W-1:0] head,
                         input logic [TAIL_W-1:0] tail, input logic [NSECT_W-1:0] sector,
                         input logic is_dir, input logic [EIDX_W-1:0] idx, input bit typed,
                         input logic [STATUS_W-1:0] status, input logic [IDX_W-1:0] index,
                         input logic [FSECT_W-1:0] fsector);
    dir_row_t row;
    row.c     = '{cmd: cmd, head: head, tail: tail, sector: sector, is_dir: is_dir, idx: idx};
    row.typed = typed;
    row.r     = '{status: status, index: index, sector: fsector};
    script.push_back(row);
  endtask

  task automatic send_cmd(input dir_cmd_t c, input bit typed, input dir_reply_t typed_reply);
    int         gap;
    dir_reply_t predicted;
    gap = draw_wait((sent_count % 160) < 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, c.idx, c.is_dir, c.sector, c.tail, c.head};
    s_axis_tuser  <= c.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = predict_reply(c);
    awaited_replies.push_back(typed ? typed_reply : predicted);
    sent_count++;
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:   return r < 60 ? CMD_ADD : r < 85 ? CMD_FIND : r < 95 ? CMD_REMOVE : CMD_LOCK;
      MODE_LOOKUP: return r < 60 ? CMD_FIND : r < 75 ? CMD_ADD : r < 95 ? CMD_REMOVE : CMD_LOCK;
      default:     return r < 50 ? CMD_REMOVE : r < 80 ? CMD_FIND : r < 90 ? CMD_ADD : CMD_LOCK;
    endcase
  endfunction

  // mostly names from a small pool so that finds hit, junk after the terminator at times
  function automatic dir_cmd_t random_cmd(int mode);
    dir_cmd_t    c;
    logic [71:0] raw;
    int          p;
    int          len;
    int          r;
    c.cmd = pick_cmd(mode);
    if ($urandom_range(0, 3) == 0) begin
      raw[31:0]  = $urandom;
      raw[63:32] = $urandom;
      raw[71:64] = 8'($urandom_range(0, 255));
    end else begin
      p   = $urandom_range(0, POOL_SIZE - 1);
      raw = pool_name[p];
      len = pool_len[p];
      for (int k = len; k < 9; k++) begin
        if (k == len || $urandom_range(0, 1) == 0) begin
          raw[8*k +: 8] = 8'd0;
        end
      end
    end
    c.head   = raw[63:0];
    c.tail   = raw[71:64];
    r        = $urandom_range(0, 9);
    c.sector = r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : NSECT_W'($urandom_range(0, 65535));
    c.is_dir = 1'($urandom_range(0, 1));
    c.idx    = EIDX_W'($urandom_range(0, 15));
    return c;
  endfunction

  initial begin : result_sink
    int         stall;
    dir_reply_t got;
    dir_reply_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_wait((results_seen % 130) < 35);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got.status = m_axis_tuser;
      got.index  = m_axis_tdata[3:0];
      got.sector = m_axis_tdata[19:4];
      results_seen++;
      if (got.status < 5) begin
        status_hits[got.status]++;
      end
      if (awaited_replies.size() == 0) begin
        report_mismatch("transfer with no command pending", got.status, 0);
      end else begin
        want = awaited_replies.pop_front();
        if (got.status != want.status) begin
          report_mismatch("status", got.status, want.status);
        end
        if (got.index != want.index) begin
          report_mismatch("found_index", got.index, want.index);
        end
        if (got.sector != want.sector) begin
          report_mismatch("found_sector", got.sector, want.sector);
        end
      end
    end
  end

  initial begin : stimulus
    dir_reply_t none;
    int         mode;
    none = '{status: ST_OK, index: '0, sector: '0};
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (used_tab[i]) begin
      used_tab[i]   = 1'b0;
      locked_tab[i] = 1'b0;
      dir_tab[i]    = 1'b0;
    end
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = $urandom_range(1, 9);
      for (int k = 0; k < 9; k++) begin
        pool_name[p][8*k +: 8] = 8'($urandom_range(1, 255));
      end
    end

    // directed rows
    add_row(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0, 0, 0, 1, ST_NOT_FOUND, 0, 0);
    add_row(CMD_REMOVE, 64'h0, 8'h0, 16'h0, 0, 0, 1, ST_BAD_INDEX, 0, 0);
    add_row(CMD_REMOVE, 64'h0, 8'h0, 16'h0, 0, 1, 1, ST_BAD_INDEX, 0, 0);
    add_row(CMD_LOCK, 64'h0, 8'h0, 16'h0, 0, 15, 1, ST_OK, 0, 0);
    add_row(CMD_REMOVE, 64'h0, 8'h0, 16'h0, 0, 15, 1, ST_OK, 0, 0);
    add_row(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 1, 0, 1, ST_OK, 0, 0);
    add_row(CMD_ADD, 64'h5A5A_0000_0000_0000, 8'h11, 16'h0, 0, 15, 1, ST_OK, 1, 0);
    add_row(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0, 0, 0, 1, ST_OK, 0, 16'hFFFF);
    add_row(CMD_FIND, 64'h0, 8'h77, 16'h0, 0, 0, 1, ST_OK, 1, 0);
    add_row(CMD_ADD, 64'hDEAD_BEEF_C000_6261, 8'hEE, 16'h1234, 0, 0, 1, ST_OK, 2, 0);
    add_row(CMD_ADD, 64'h0000_0000_0000_6261, 8'h00, 16'h4321, 1, 0, 1, ST_OK, 3, 0);
    add_row(CMD_FIND, 64'h0000_0000_0000_6261, 8'h33, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_LOCK, 64'h0, 8'h0, 16'h0, 0, 2, 1, ST_OK, 0, 0);
    add_row(CMD_FIND, 64'h0101_0000_0000_6261, 8'h00, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_REMOVE, 64'h0, 8'h0, 16'h0, 0, 2, 1, ST_OK, 0, 0);
    add_row(CMD_FIND, 64'h0000_0000_0000_6261, 8'h00, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_ADD, 64'h0000_0000_0000_6261, 8'h00, 16'h0BAD, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_FIND, 64'h0000_0000_0000_6261, 8'h00, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_ADD, 64'h4847_4645_4443_4241, 8'h49, 16'h8000, 1, 0, 0, none.status, 0, 0);
    add_row(CMD_FIND, 64'h4847_4645_4443_4241, 8'h4A, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_FIND, 64'h4847_4645_4443_4241, 8'h00, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_FIND, 64'h4847_4645_4443_4241, 8'h49, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_LOCK, 64'h0, 8'h0, 16'h0, 0, 0, 1, ST_OK, 0, 0);
    add_row(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'h0, 0, 0, 0, none.status, 0, 0);
    add_row(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 1, 1, 1, ST_BAD_INDEX, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_cmd(script[i].c, script[i].typed, script[i].r);
    end

    mode = MODE_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0 && n > 0) begin
        mode = $urandom_range(MODE_FILL, MODE_DRAIN);
      end
      send_cmd(random_cmd(mode), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked, %0d mismatches", sent_count,
             results_seen, error_count);
    $display("status ok %0d, not found %0d, unopenable %0d, full %0d, bad index %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (error_count == 0) begin
      $display("directory_name_table_tb: done, clean");
    end else begin
      $display("directory_name_table_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dnt_pkg.sv
src/dnt_cell.sv
src/directory_name_table.sv
dv/directory_name_table_tb.sv
